// ----- rtl/sbh_pkg.sv -----
// ----------------------------------------------------------------------------
// sbh_pkg
// Shared types for the SHA-256 byte stream hasher: hash words, the packed
// eight-word working set and the sequencer states.
// ----------------------------------------------------------------------------
package sbh_pkg;

  typedef logic [31:0] word_t;

  // Element 0 is word a (or hash word 0), element 7 is word h
  typedef logic [7:0][31:0] hash_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_FOLD,
    ST_OUT
  } state_t;

  localparam int unsigned ROUND_W = 6;

endpackage

// ----- rtl/sha256_byte_stream_hasher_top.sv -----
// Flow: a data byte is shifted in directly; the 64th byte of a block starts the 64
// rounds in the shared round unit, then the working set is folded into the hash.
// Finish: the 0x80 byte, padding (one byte a cycle, with a pause at the length slot
// before the length bytes, over one or two blocks), each block compressed, then 8 digest words.
// Throughput: input bytes only in idle; digest words go one per cycle while out_ready.
// Reset: synchronous, loads the initial hash and clears counts; buffer kept.
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_top
// SHA-256 over a byte stream: bytes collect in a 512-bit shift line that also
// serves as the message schedule; one round unit runs the 64 rounds.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sbh_pkg::*;

  localparam hash_t IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };
  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam logic [5:0] FILL_LAST   = 6'd63;
  localparam logic [5:0] ROUND_LAST  = 6'd63;
  localparam logic [2:0] WORD_LAST   = 3'd7;

  state_t        state_r, state_nxt;
  logic [5:0]    fill_r, fill_nxt;
  logic [63:0]   total_r, total_nxt;
  logic          fin_r, fin_nxt;
  logic          len_r, len_nxt;
  logic [2:0]    idx_r, idx_nxt;
  logic [5:0]    rnd_r, rnd_nxt;
  hash_t         hash_r, hash_nxt;
  hash_t         vars_r, vars_nxt;
  logic [511:0]  blk_r, blk_nxt;
  logic [63:0]   lensr_r, lensr_nxt;

  logic          shift_en;
  logic [7:0]    shift_byte;
  hash_t         round_vars;
  word_t         round_w;

  sbh_round u_round (
    .round_idx (rnd_r),
    .vars_cur  (vars_r),
    .w_t0      (blk_r[511:480]),
    .w_t1      (blk_r[479:448]),
    .w_t9      (blk_r[223:192]),
    .w_t14     (blk_r[63:32]),
    .vars_nxt  (round_vars),
    .w_new     (round_w)
  );

  // Sequencer: collect, pad, compress, fold, emit
  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    total_nxt  = total_r;
    fin_nxt    = fin_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    rnd_nxt    = rnd_r;
    hash_nxt   = hash_r;
    vars_nxt   = vars_r;
    blk_nxt    = blk_r;
    lensr_nxt  = lensr_r;
    shift_en   = 1'b0;
    shift_byte = '0;
    in_ready   = 1'b0;
    out_valid  = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          shift_en = 1'b1;
          if (in_command) begin
            shift_byte = PAD_BYTE;
            fin_nxt    = 1'b1;
            len_nxt    = 1'b0;
            lensr_nxt  = {total_r[60:0], 3'b000};
          end else begin
            shift_byte = in_data_byte;
            total_nxt  = total_r + 64'd1;
          end
          if (fill_r == FILL_LAST) begin
            state_nxt = ST_COMP;
            vars_nxt  = hash_r;
            rnd_nxt   = '0;
          end else if (in_command) begin
            state_nxt = ST_PAD;
          end
        end
      end

      ST_PAD: begin
        // Zero up to the length slot, then feed the length bytes
        if (!len_r && fill_r == LEN_POS) begin
          len_nxt = 1'b1;
        end else begin
          shift_en = 1'b1;
          if (len_r) begin
            shift_byte = lensr_r[63:56];
            lensr_nxt  = {lensr_r[55:0], 8'h00};
          end
          if (fill_r == FILL_LAST) begin
            state_nxt = ST_COMP;
            vars_nxt  = hash_r;
            rnd_nxt   = '0;
          end
        end
      end

      ST_COMP: begin
        vars_nxt = round_vars;
        blk_nxt  = {blk_r[479:0], round_w};
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == ROUND_LAST) begin
          state_nxt = ST_FOLD;
        end
      end

      ST_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          hash_nxt[i] = hash_r[i] + vars_r[i];
        end
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (len_r) begin
          state_nxt = ST_OUT;
          idx_nxt   = '0;
        end else begin
          state_nxt = ST_PAD;
        end
      end

      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          hash_nxt = {hash_r[0], hash_r[7:1]};
          idx_nxt  = idx_r + 3'd1;
          if (idx_r == WORD_LAST) begin
            hash_nxt  = IV;
            fill_nxt  = '0;
            total_nxt = '0;
            fin_nxt   = 1'b0;
            len_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Push one byte into the block shift line
    if (shift_en) begin
      blk_nxt  = {blk_r[503:0], shift_byte};
      fill_nxt = fill_r + 6'd1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      total_r <= '0;
      fin_r   <= 1'b0;
      len_r   <= 1'b0;
      idx_r   <= '0;
      rnd_r   <= '0;
      hash_r  <= IV;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      total_r <= total_nxt;
      fin_r   <= fin_nxt;
      len_r   <= len_nxt;
      idx_r   <= idx_nxt;
      rnd_r   <= rnd_nxt;
      hash_r  <= hash_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    vars_r  <= vars_nxt;
    blk_r   <= blk_nxt;
    lensr_r <= lensr_nxt;
  end

  assign out_digest_word = hash_r[0];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == WORD_LAST);

endmodule

// ----- rtl/sbh_round.sv -----
// ----------------------------------------------------------------------------
// sbh_round
// One SHA-256 compression round and one message schedule expansion step.
// Used once per cycle by the sequencer in the top level.
// ----------------------------------------------------------------------------
module sbh_round (
  input  logic [sbh_pkg::ROUND_W-1:0] round_idx,
  input  sbh_pkg::hash_t              vars_cur,
  input  sbh_pkg::word_t              w_t0,
  input  sbh_pkg::word_t              w_t1,
  input  sbh_pkg::word_t              w_t9,
  input  sbh_pkg::word_t              w_t14,
  output sbh_pkg::hash_t              vars_nxt,
  output sbh_pkg::word_t              w_new
);
  import sbh_pkg::*;

  localparam word_t K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t bsig0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t bsig1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t ssig0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t ssig1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  word_t t1;
  word_t t2;
  word_t ch;
  word_t maj;

  // Round function on a..h
  always_comb begin
    ch  = (vars_cur[4] & vars_cur[5]) ^ (~vars_cur[4] & vars_cur[6]);
    maj = (vars_cur[0] & vars_cur[1]) ^ (vars_cur[0] & vars_cur[2]) ^
          (vars_cur[1] & vars_cur[2]);
    t1  = vars_cur[7] + bsig1(vars_cur[4]) + ch + K_TAB[round_idx] + w_t0;
    t2  = bsig0(vars_cur[0]) + maj;
    vars_nxt[0] = t1 + t2;
    vars_nxt[1] = vars_cur[0];
    vars_nxt[2] = vars_cur[1];
    vars_nxt[3] = vars_cur[2];
    vars_nxt[4] = vars_cur[3] + t1;
    vars_nxt[5] = vars_cur[4];
    vars_nxt[6] = vars_cur[5];
    vars_nxt[7] = vars_cur[6];
  end

  // Schedule word sixteen places ahead of the current one
  assign w_new = w_t0 + ssig0(w_t1) + w_t9 + ssig1(w_t14);

endmodule

// ----- rtl/sbh_checker.sv -----
// ----------------------------------------------------------------------------
// sbh_checker
// Port-level checks for the SHA-256 byte stream hasher, bound to the top.
// ----------------------------------------------------------------------------
module sbh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_index,
  input logic        out_last_word
);

  // Never take a byte while the digest is being emitted
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while digest words are pending");

  // Hold a stalled digest word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_digest_word) && $stable(out_word_index)))
    else $error("digest word changed while stalled");

  // Advance the word index after each taken non-final word
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_word) |=>
      (out_valid && out_word_index == $past(out_word_index) + 3'd1))
    else $error("digest word index did not advance");

  // Last mark tracks the final index
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last mark does not match word index");

  // Return to accepting input after the final word
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_word) |=> (in_ready && !out_valid))
    else $error("block did not restart after the digest");

endmodule

bind sha256_byte_stream_hasher_top sbh_checker u_sbh_checker (.*);
